FILE: hw/rtl/mmenv_pkg.sv
package mmenv_pkg;

	localparam int unsigned STORE_PAIRS_DEF = 1024;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam int unsigned ZOOM_W  = 25;
	localparam int unsigned FILL_W  = ZOOM_W - 1;
	localparam int unsigned START_W = 17;
	localparam int unsigned CAP_W   = 10;
	localparam int unsigned CFG_W   = START_W;

	localparam logic [ZOOM_W-1:0] ZOOM_HALF_CEIL = ZOOM_W'(1 << 23);
	localparam logic [CAP_W-1:0]  CAP_RESET      = CAP_W'(1022);

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic {
		CFG_START_ZOOM = 1'b0,
		CFG_CAPACITY   = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_WINDOW = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_READ,
		ST_CMP_RD0,
		ST_CMP_RD1,
		ST_CMP_WR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic store;
		logic read_done;
		logic cmp_rd0;
		logic cmp_rd1;
		logic cmp_wr;
		logic emit;
	} mmenv_cmd_t;

	typedef struct packed {
		logic is_read;
		logic close_now;
		logic cmp_go;
		logic cmp_last;
		logic out_free;
	} mmenv_sts_t;

endpackage

FILE: hw/rtl/mmenv_in_if.sv
interface mmenv_in_if #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned INDEX_W     = 10
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [INDEX_W-1:0]            entry_index;

	modport source (output valid, opcode, sample, entry_index, input ready);
	modport sink (input valid, opcode, sample, entry_index, output ready);
endinterface

FILE: hw/rtl/mmenv_out_if.sv
interface mmenv_out_if #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned COUNT_W     = 11,
	parameter int unsigned ZOOM_BITS   = 25
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] peak_max;
	logic signed [SAMPLE_BITS-1:0] peak_min;
	logic [COUNT_W-1:0]            pair_count;
	logic [ZOOM_BITS-1:0]          zoom;
	logic                          overflow;

	modport source (output valid, kind, peak_max, peak_min, pair_count, zoom, overflow,
		input ready);
	modport sink (input valid, kind, peak_max, peak_min, pair_count, zoom, overflow,
		output ready);
endinterface

FILE: hw/rtl/mmenv_ram.sv
module mmenv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/mmenv_ctrl.sv
module mmenv_ctrl
	import mmenv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mmenv_sts_t sts,
	output mmenv_cmd_t cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					if (sts.is_read) begin
						state_d = ST_READ;
					end else if (sts.close_now) begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_CLOSE: begin
				cmd.store = 1'b1;
				state_d   = sts.cmp_go ? ST_CMP_RD0 : ST_EMIT;
			end
			ST_READ: begin
				cmd.read_done = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_CMP_RD0: begin
				cmd.cmp_rd0 = 1'b1;
				state_d     = ST_CMP_RD1;
			end
			ST_CMP_RD1: begin
				cmd.cmp_rd1 = 1'b1;
				state_d     = ST_CMP_WR;
			end
			ST_CMP_WR: begin
				cmd.cmp_wr = 1'b1;
				state_d    = sts.cmp_last ? ST_EMIT : ST_CMP_RD0;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: hw/rtl/mmenv_dp.sv
module mmenv_dp
	import mmenv_pkg::*;
#(
	parameter int unsigned STORE_PAIRS = STORE_PAIRS_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int unsigned AW         = $clog2(STORE_PAIRS),
	localparam int unsigned CW         = AW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic [1:0]                    in_opcode,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic [AW-1:0]                 in_entry_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_kind,
	output logic signed [SAMPLE_BITS-1:0] out_peak_max,
	output logic signed [SAMPLE_BITS-1:0] out_peak_min,
	output logic [CW-1:0]                 out_pair_count,
	output logic [ZOOM_W-1:0]             out_zoom,
	output logic                          out_overflow,
	input  mmenv_cmd_t                    cmd,
	output mmenv_sts_t                    sts
);
	localparam int unsigned DW = 2 * SAMPLE_BITS;

	logic [ZOOM_W-1:0]             zoom_q;
	logic [CAP_W-1:0]              capacity_q;
	logic [CW-1:0]                 stored_q;
	logic [FILL_W-1:0]             fill_q;
	logic signed [SAMPLE_BITS-1:0] run_max_q;
	logic signed [SAMPLE_BITS-1:0] run_min_q;
	logic [AW-1:0]                 idx_q;
	logic [AW-1:0]                 half_q;
	logic [AW-1:0]                 j_q;
	logic [DW-1:0]                 hold_q;

	logic                          res_kind_q;
	logic signed [SAMPLE_BITS-1:0] res_max_q;
	logic signed [SAMPLE_BITS-1:0] res_min_q;
	logic                          res_ovf_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic signed [SAMPLE_BITS-1:0] out_max_q;
	logic signed [SAMPLE_BITS-1:0] out_min_q;
	logic [CW-1:0]                 out_count_q;
	logic [ZOOM_W-1:0]             out_zoom_q;
	logic                          out_ovf_q;

	op_t                           op;
	logic [ZOOM_W-1:0]             fill_inc;
	logic signed [SAMPLE_BITS-1:0] max_nx;
	logic signed [SAMPLE_BITS-1:0] min_nx;
	logic                          full;
	logic [CW-1:0]                 cnt_inc;
	logic                          in_range;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [DW-1:0]                 ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [DW-1:0]                 ram_rdata;

	logic signed [SAMPLE_BITS-1:0] a_max;
	logic signed [SAMPLE_BITS-1:0] a_min;
	logic signed [SAMPLE_BITS-1:0] b_max;
	logic signed [SAMPLE_BITS-1:0] b_min;
	logic signed [SAMPLE_BITS-1:0] m_max;
	logic signed [SAMPLE_BITS-1:0] m_min;

	always_comb begin
		op       = op_t'(in_opcode);
		fill_inc = ZOOM_W'(fill_q) + ZOOM_W'(1);
		if (fill_q == '0) begin
			max_nx = in_sample;
			min_nx = in_sample;
		end else begin
			max_nx = (in_sample > run_max_q) ? in_sample : run_max_q;
			min_nx = (in_sample < run_min_q) ? in_sample : run_min_q;
		end
		full     = stored_q >= CW'(STORE_PAIRS);
		cnt_inc  = stored_q + CW'(1);
		in_range = CW'(idx_q) < stored_q;

		a_max = hold_q[DW-1:SAMPLE_BITS];
		a_min = hold_q[SAMPLE_BITS-1:0];
		b_max = ram_rdata[DW-1:SAMPLE_BITS];
		b_min = ram_rdata[SAMPLE_BITS-1:0];
		m_max = (a_max > b_max) ? a_max : b_max;
		m_min = (a_min < b_min) ? a_min : b_min;

		sts.is_read = (op == OP_READ);
		case (op)
			OP_SAMPLE: sts.close_now = fill_inc >= zoom_q;
			OP_FLUSH:  sts.close_now = fill_q != '0;
			default:   sts.close_now = 1'b0;
		endcase
		sts.cmp_go   = !full && (32'(cnt_inc) > 32'(capacity_q)) && !cnt_inc[0]
			&& (zoom_q <= ZOOM_HALF_CEIL);
		sts.cmp_last = (j_q + AW'(1)) == half_q;
		sts.out_free = !out_valid_q || out_ready;

		if (cmd.cmp_rd0) begin
			ram_raddr = {j_q[AW-2:0], 1'b0};
		end else if (cmd.cmp_rd1) begin
			ram_raddr = {j_q[AW-2:0], 1'b1};
		end else begin
			ram_raddr = in_entry_index;
		end
		ram_we = (cmd.store && !full) || cmd.cmp_wr;
		if (cmd.cmp_wr) begin
			ram_waddr = j_q;
			ram_wdata = {m_max, m_min};
		end else begin
			ram_waddr = stored_q[AW-1:0];
			ram_wdata = {run_max_q, run_min_q};
		end
	end

	mmenv_ram #(
		.WIDTH(DW),
		.DEPTH(STORE_PAIRS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q      <= ZOOM_W'(1);
			capacity_q  <= CAP_RESET;
			stored_q    <= '0;
			fill_q      <= '0;
			run_max_q   <= '0;
			run_min_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_ZOOM: begin
						// zero start zoom acts as one
						zoom_q <= (cfg_data == '0) ? ZOOM_W'(1) : ZOOM_W'(cfg_data);
						fill_q <= '0;
					end
					CFG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept && op == OP_SAMPLE) begin
				run_max_q <= max_nx;
				run_min_q <= min_nx;
				fill_q    <= sts.close_now ? '0 : fill_inc[FILL_W-1:0];
			end
			if (cmd.accept && op == OP_FLUSH) begin
				fill_q <= '0;
			end
			if (cmd.store && !full) begin
				stored_q <= cnt_inc;
			end
			if (cmd.cmp_wr && sts.cmp_last) begin
				stored_q <= CW'(half_q);
				zoom_q   <= zoom_q << 1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q <= in_entry_index;
		end
		if (cmd.store) begin
			res_kind_q <= KIND_WINDOW;
			res_max_q  <= run_max_q;
			res_min_q  <= run_min_q;
			res_ovf_q  <= full;
			half_q     <= cnt_inc[AW:1];
			j_q        <= '0;
		end
		if (cmd.read_done) begin
			res_kind_q <= KIND_READ;
			res_max_q  <= in_range ? b_max : '0;
			res_min_q  <= in_range ? b_min : '0;
			res_ovf_q  <= 1'b0;
		end
		if (cmd.cmp_rd1) begin
			hold_q <= ram_rdata;
		end
		if (cmd.cmp_wr) begin
			j_q <= j_q + AW'(1);
		end
		// count and zoom are taken after any compaction
		if (cmd.emit) begin
			out_kind_q  <= res_kind_q;
			out_max_q   <= res_max_q;
			out_min_q   <= res_min_q;
			out_ovf_q   <= res_ovf_q;
			out_count_q <= stored_q;
			out_zoom_q  <= zoom_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_peak_max   = out_max_q;
	assign out_peak_min   = out_min_q;
	assign out_pair_count = out_count_q;
	assign out_zoom       = out_zoom_q;
	assign out_overflow   = out_ovf_q;
endmodule

FILE: hw/rtl/minmax_envelope_decimator.sv
// A sample that does not finish its window leaves the block idle; the next word is taken at once.
// A finished window, a non-empty flush or a read puts its result word out through the result
// register (store or envelope RAM read) and then the output register, which waits while the
// output is not free; the next word is taken only once the result word has gone out.
// Compaction merges count/2 pairs, each with two reads on one RAM read port and a write.
// Reset (arst_n low, asynchronous) clears count, fill, out valid; zoom goes to 1; RAM kept.
module minmax_envelope_decimator
	import mmenv_pkg::*;
#(
	parameter int unsigned STORE_PAIRS = STORE_PAIRS_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	mmenv_in_if.sink         in_ch,
	mmenv_out_if.source      out_ch
);
	mmenv_cmd_t cmd;
	mmenv_sts_t sts;

	mmenv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mmenv_dp #(
		.STORE_PAIRS(STORE_PAIRS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_opcode     (in_ch.opcode),
		.in_sample     (in_ch.sample),
		.in_entry_index(in_ch.entry_index),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_kind      (out_ch.kind),
		.out_peak_max  (out_ch.peak_max),
		.out_peak_min  (out_ch.peak_min),
		.out_pair_count(out_ch.pair_count),
		.out_zoom      (out_ch.zoom),
		.out_overflow  (out_ch.overflow),
		.cmd           (cmd),
		.sts           (sts)
	);
endmodule
